[rtl/gmde_pkg.sv]
// gmde_pkg: shared constants and types for the gaussian mixture density evaluator
// no dependencies
`default_nettype none
package gmde_pkg;
   localparam int MaxComponents = 16;
   localparam int IdxW          = $clog2(MaxComponents);
   localparam int CntW          = $clog2(MaxComponents + 1);
   localparam int QueueDepth    = 2;

   localparam logic [31:0] InvSqrt2PiQ32 = 32'd1713444047;
   localparam logic [31:0] Log2eQ30      = 32'd1549082005;
   localparam logic [31:0] Ln2Q30        = 32'd744261118;
   localparam logic [30:0] OneQ30        = 31'h4000_0000;
   localparam logic [35:0] ZLimit        = 36'd12 << 16;
   localparam int SeriesTerms            = 12;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } cmd_type;

   // one queued job between front and back
   typedef struct packed {
      cmd_type         cmd;
      logic [IdxW-1:0] slot;
      logic [15:0]     weight;
      logic [31:0]     mean;
      logic [31:0]     variance;
      logic [31:0]     point;
   } job_type;
endpackage
`default_nettype wire

[rtl/gmde_req_if.sv]
// gmde_req_if: request channel (valid/ready plus input item)
// depends on nothing
`default_nettype none
interface gmde_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [3:0]  component_index;
   logic [15:0] comp_weight_in;
   logic [31:0] comp_mean_in;
   logic [31:0] comp_variance_in;
   logic [31:0] grid_point;
   modport source (output valid, command, component_index, comp_weight_in,
                   comp_mean_in, comp_variance_in, grid_point, input ready);
   modport sink   (input valid, command, component_index, comp_weight_in,
                   comp_mean_in, comp_variance_in, grid_point, output ready);
endinterface
`default_nettype wire

[rtl/gmde_rsp_if.sv]
// gmde_rsp_if: result channel (valid/ready plus density and flag)
// depends on nothing
`default_nettype none
interface gmde_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] density;
   logic        saturated;
   modport source (output valid, density, saturated, input ready);
   modport sink   (input valid, density, saturated, output ready);
endinterface
`default_nettype wire

[rtl/gmde_ram.sv]
// gmde_ram: generic single-write, single-read ram with registered read
// no dependencies
`default_nettype none
module gmde_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/gmde_front.sv]
// gmde_front: accepts request transfers and queues them as jobs
// depends on gmde_pkg, gmde_req_if
`default_nettype none
module gmde_front (
   input  wire logic          clock,
   input  wire logic          reset,
   gmde_req_if.sink           req,
   output gmde_pkg::job_type  job,
   output logic               job_valid,
   input  wire logic          job_pop
);
   localparam int PtrW = $clog2(gmde_pkg::QueueDepth);

   gmde_pkg::job_type   q_ff [gmde_pkg::QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]       count_ff;
   logic                push;
   gmde_pkg::job_type   incoming;

   assign req.ready = (count_ff != (PtrW+1)'(gmde_pkg::QueueDepth));
   assign push      = req.valid && req.ready;
   assign job_valid = (count_ff != '0);
   assign job       = q_ff[rd_ptr_ff];

   // classify the transfer into a job
   always_comb begin
      incoming.cmd      = gmde_pkg::cmd_type'(req.command);
      incoming.slot     = req.component_index[gmde_pkg::IdxW-1:0];
      incoming.weight   = req.comp_weight_in;
      incoming.mean     = req.comp_mean_in;
      incoming.variance = req.comp_variance_in;
      incoming.point    = req.grid_point;
   end

   // small fifo
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            q_ff[wr_ptr_ff] <= incoming;
            wr_ptr_ff       <= wr_ptr_ff + 1'b1;
         end
         if (job_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PtrW+1)'(push) - (PtrW+1)'(job_pop);
      end
   end
endmodule
`default_nettype wire

[rtl/gmde_back.sv]
// gmde_back: sequencer for loads (sqrt of reciprocal) and evals (per-component sum)
// depends on gmde_pkg, gmde_ram
`default_nettype none
module gmde_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [4:0]              active_count,
   input  wire gmde_pkg::job_type       job,
   input  wire logic                    job_valid,
   output logic                         job_pop,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [31:0]                  out_sum,
   output logic                         out_saturated
);
   typedef enum logic [4:0] {
      ST_IDLE, ST_DIV, ST_SQRT, ST_SC1, ST_SC2, ST_WRITE,
      ST_RD, ST_RDW, ST_D, ST_M, ST_A, ST_B, ST_Y, ST_SER, ST_SER2, ST_E, ST_T,
      ST_ACC, ST_OUT
   } state_type;

   state_type        state_ff;
   // divider / sqrt working registers
   logic [56:0]      rem_ff;
   logic [32:0]      divsr_ff;
   logic [56:0]      quo_ff;
   logic [5:0]       step_ff;
   logic [63:0]      root_ff;
   logic [63:0]      val_ff;
   logic [63:0]      bit_ff;
   // eval working registers
   logic [gmde_pkg::IdxW-1:0] idx_ff;
   logic [gmde_pkg::CntW-1:0] cnt_ff;
   logic [32:0]      mag_ff;
   logic [63:0]      prod_ff;
   logic [35:0]      m_ff;
   logic [30:0]      p_ff;
   logic [3:0]       n_ff;
   logic [29:0]      y_ff;
   logic [29:0]      yp_ff;
   logic [6:0]       k_ff;
   logic [32:0]      sum_ff;
   logic             sat_ff;
   logic [31:0]      scale_ff;
   logic [31:0]      density_ff;
   logic             satout_ff;
   logic             outv_ff;

   // tables
   logic             wr_en;
   logic [31:0]      rd_mean, rd_inv, rd_scale;
   logic [31:0]      inv_w;
   logic [31:0]      scale_w;
   logic [gmde_pkg::IdxW-1:0] rd_addr;

   assign wr_en   = (state_ff == ST_WRITE);
   assign inv_w   = root_ff[31:0];
   assign scale_w = {4'd0, prod_ff[63:36]};
   assign rd_addr = idx_ff;

   gmde_ram #(.Width(32), .Depth(gmde_pkg::MaxComponents)) u_mean (
      .clock, .wr_en, .wr_addr(job.slot), .wr_data(job.mean),
      .rd_addr, .rd_data(rd_mean));
   gmde_ram #(.Width(32), .Depth(gmde_pkg::MaxComponents)) u_inv (
      .clock, .wr_en, .wr_addr(job.slot), .wr_data(inv_w),
      .rd_addr, .rd_data(rd_inv));
   gmde_ram #(.Width(32), .Depth(gmde_pkg::MaxComponents)) u_scale (
      .clock, .wr_en, .wr_addr(job.slot), .wr_data(scale_w),
      .rd_addr, .rd_data(rd_scale));

   assign job_pop       = (state_ff == ST_WRITE) ||
                          (state_ff == ST_OUT && !(outv_ff && !out_ready));
   assign out_valid     = outv_ff;
   assign out_sum       = density_ff;
   assign out_saturated = satout_ff;

   // combinational helpers
   logic [57:0] div_trial;
   logic [64:0] sq_trial;
   logic [32:0] d_signed;
   logic [gmde_pkg::CntW-1:0] cnt_clamped;
   logic [33:0] sum_next;
   logic [61:0] yp;
   logic [34:0] recip_n;
   logic [63:0] q_prod;

   always_comb begin
      div_trial = {rem_ff, quo_ff[56]} - {25'd0, divsr_ff};
      sq_trial  = {1'b0, val_ff} - {1'b0, root_ff + bit_ff};
      d_signed  = {job.point[31], job.point} - {rd_mean[31], rd_mean};
      if (active_count > 5'(gmde_pkg::MaxComponents)) begin
         cnt_clamped = gmde_pkg::CntW'(gmde_pkg::MaxComponents);
      end else begin
         cnt_clamped = gmde_pkg::CntW'(active_count);
      end
      sum_next = {1'b0, sum_ff} + {4'b0, prod_ff[63:34]};
      yp       = 62'(y_ff) * 62'(p_ff);
      q_prod   = 64'(yp_ff) * 64'(recip_n);
   end

   // ceil(2^34 / n), exact floor division for dividends below 2^30
   always_comb begin
      case (n_ff)
         4'd1:    recip_n = 35'd17179869184;
         4'd2:    recip_n = 35'd8589934592;
         4'd3:    recip_n = 35'd5726623062;
         4'd4:    recip_n = 35'd4294967296;
         4'd5:    recip_n = 35'd3435973837;
         4'd6:    recip_n = 35'd2863311531;
         4'd7:    recip_n = 35'd2454267027;
         4'd8:    recip_n = 35'd2147483648;
         4'd9:    recip_n = 35'd1908874354;
         4'd10:   recip_n = 35'd1717986919;
         4'd11:   recip_n = 35'd1561806290;
         4'd12:   recip_n = 35'd1431655766;
         default: recip_n = 35'd0;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         outv_ff  <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && !(outv_ff && !out_ready)) begin
            outv_ff <= 1'b1;
         end else if (outv_ff && out_ready) begin
            outv_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  if (job.cmd == gmde_pkg::CMD_LOAD) begin
                     rem_ff   <= '0;
                     quo_ff   <= 57'd1 << 56;
                     divsr_ff <= {1'b0, (job.variance == '0) ? 32'd1 : job.variance};
                     step_ff  <= 6'd0;
                     state_ff <= ST_DIV;
                  end else begin
                     idx_ff   <= '0;
                     cnt_ff   <= cnt_clamped;
                     sum_ff   <= '0;
                     sat_ff   <= 1'b0;
                     state_ff <= (cnt_clamped == '0) ? ST_OUT : ST_RD;
                  end
               end
            end
            // restoring division 2^56 / var, one quotient bit a cycle
            ST_DIV: begin
               if (!div_trial[57]) begin
                  rem_ff <= div_trial[56:0];
                  quo_ff <= {quo_ff[55:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[55:0], quo_ff[56]};
                  quo_ff <= {quo_ff[55:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == 6'd56) begin
                  state_ff <= ST_SQRT;
                  root_ff  <= '0;
                  bit_ff   <= 64'd1 << 62;
               end
               if (step_ff == 6'd56) begin
                  val_ff <= {7'd0, (!div_trial[57]) ? {quo_ff[55:0], 1'b1}
                                                    : {quo_ff[55:0], 1'b0}};
               end
            end
            // bitwise integer square root, one result bit a cycle
            ST_SQRT: begin
               if (bit_ff == '0) begin
                  state_ff <= ST_SC1;
               end else begin
                  if (!sq_trial[64]) begin
                     val_ff  <= sq_trial[63:0];
                     root_ff <= (root_ff >> 1) + bit_ff;
                  end else begin
                     root_ff <= root_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            ST_SC1: begin
               prod_ff  <= 64'(job.weight) * 64'(root_ff[31:0]);
               state_ff <= ST_SC2;
            end
            ST_SC2: begin
               prod_ff  <= 64'(prod_ff[43:12]) * 64'(gmde_pkg::InvSqrt2PiQ32);
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               state_ff <= ST_IDLE;
            end
            ST_RD: begin
               state_ff <= ST_RDW;
            end
            ST_RDW: begin
               mag_ff   <= d_signed[32] ? (33'd0 - d_signed) : d_signed;
               scale_ff <= rd_scale;
               state_ff <= ST_D;
            end
            ST_D: begin
               prod_ff  <= 64'(mag_ff) * 64'(rd_inv);
               state_ff <= ST_M;
            end
            ST_M: begin
               m_ff <= prod_ff[55:20];
               if (prod_ff[63:20] >= 44'(gmde_pkg::ZLimit)) begin
                  state_ff <= ST_ACC;
                  prod_ff  <= '0;
               end else begin
                  state_ff <= ST_A;
               end
            end
            ST_A: begin
               prod_ff  <= 64'(m_ff[19:0]) * 64'(m_ff[19:0]);
               state_ff <= ST_B;
            end
            ST_B: begin
               prod_ff  <= 64'(prod_ff[39:17]) * 64'(gmde_pkg::Log2eQ30);
               state_ff <= ST_Y;
            end
            ST_Y: begin
               k_ff     <= (prod_ff[63:46] >= 18'd31) ? 7'd31 : 7'(prod_ff[50:46]);
               prod_ff  <= 64'(prod_ff[45:16]) * 64'(gmde_pkg::Ln2Q30);
               state_ff <= ST_SER;
               p_ff     <= gmde_pkg::OneQ30;
               n_ff     <= 4'(gmde_pkg::SeriesTerms);
               y_ff     <= '0;
               step_ff  <= 6'd0;
            end
            // horner series, each term a product, then a divide
            ST_SER: begin
               if (step_ff == 6'd0) begin
                  y_ff    <= prod_ff[59:30];
                  step_ff <= 6'd1;
               end else begin
                  yp_ff    <= yp[59:30];
                  state_ff <= ST_SER2;
               end
            end
            ST_SER2: begin
               p_ff <= gmde_pkg::OneQ30 - {1'b0, q_prod[63:34]};
               n_ff <= n_ff - 1'b1;
               if (n_ff == 4'd1) begin
                  state_ff <= ST_E;
               end else begin
                  state_ff <= ST_SER;
               end
            end
            ST_E: begin
               prod_ff  <= (k_ff >= 7'd31) ? 64'd0
                           : 64'(scale_ff) * 64'(p_ff >> k_ff[4:0]);
               state_ff <= ST_T;
            end
            ST_T: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (sum_next[33:32] != 2'b00) begin
                  sum_ff <= 33'h0_FFFF_FFFF;
                  sat_ff <= 1'b1;
               end else begin
                  sum_ff <= sum_next[32:0];
               end
               idx_ff <= idx_ff + 1'b1;
               if (cnt_ff == gmde_pkg::CntW'(1)) begin
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_RD;
               end
               cnt_ff <= cnt_ff - 1'b1;
            end
            ST_OUT: begin
               if (!(outv_ff && !out_ready)) begin
                  density_ff <= sum_ff[31:0];
                  satout_ff  <= sat_ff;
                  state_ff   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[rtl/gaussian_mixture_density_eval.sv]
// gaussian_mixture_density_eval: top level, front queue plus back sequencer
// depends on gmde_pkg, gmde_req_if, gmde_rsp_if, gmde_front, gmde_back
//
// channel   dir  payload
// req       in   command, component_index, comp_weight_in, comp_mean_in,
//                comp_variance_in, grid_point
// rsp       out  density, saturated
// csr       in   active_components (csr_wr_en, csr_wr_data)
//
// a load runs dispatch, the bit-serial reciprocal, the bit-serial square root,
// two scaling multiplies and the table write. an eval runs, per active
// component, a table read, multiplies and a 12-term series (a product and a
// divide per term), and skips the series when the point is 12 sigma out.
// reset is synchronous; the tables are undefined until loaded. requests
// queue two deep; a stalled result holds the back sequencer.
`default_nettype none
module gaussian_mixture_density_eval (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_wr_en,
   input  wire logic [4:0] csr_wr_data,
   gmde_req_if.sink   req,
   gmde_rsp_if.source rsp
);
   logic [4:0]         active_ff;
   gmde_pkg::job_type  job;
   logic               job_valid, job_pop;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 5'd1;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   gmde_front u_front (
      .clock, .reset, .req, .job, .job_valid, .job_pop);

   gmde_back u_back (
      .clock, .reset, .active_count(active_ff), .job, .job_valid, .job_pop,
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_sum(rsp.density), .out_saturated(rsp.saturated));
endmodule
`default_nettype wire
